// ===== sv/chained_hash_set_assert.svh =====
// assertion macros used by the checker file
`ifndef CHAINED_HASH_SET_ASSERT_SVH
`define CHAINED_HASH_SET_ASSERT_SVH

// property checked outside reset
`define CHS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("chained_hash_set assertion failed");

// property checked at every edge, reset included
`define CHS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("chained_hash_set assertion failed");

`endif

// ===== sv/chs_pkg.sv =====
// shared types and codes of the chained hash set
package chs_pkg;

    localparam int KEY_W  = 31;
    localparam int CFG_W  = 9;
    localparam int REM_W  = 9;
    localparam int CNT_W  = 5;
    localparam int OUT_BW = 8;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_SEARCH  = 2'd2;
    localparam logic [1:0] OP_INVALID = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [OUT_BW-1:0] bucket;
    } t_rsp;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_LOAD,
        ACT_DIV,
        ACT_RD_BUCKET,
        ACT_ALLOC_RD,
        ACT_ALLOC,
        ACT_LINK,
        ACT_WALK_START,
        ACT_RD_NODE,
        ACT_ADVANCE,
        ACT_UNLINK,
        ACT_FREE,
        ACT_RESULT
    } t_act;

    typedef struct packed {
        t_act       act;
        logic [1:0] res;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       div_done;
        logic [1:0] op;
        logic       free_nil;
        logic       fresh_nil;
        logic       link_head;
        logic       cur_nil;
        logic       match;
        logic       out_busy;
    } t_sts;

endpackage

// ===== sv/chs_stream_if.sv =====
// valid/ready channel carrying one item
interface chs_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/chs_ctrl.sv =====
// sequencer of the chained hash set
module chs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  chs_pkg::t_sts i_sts,
    output chs_pkg::t_cmd o_cmd
);
    import chs_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_DIV   = 11'b000_0000_0100,
        S_RDB   = 11'b000_0000_1000,
        S_DISP  = 11'b000_0001_0000,
        S_ALLOC = 11'b000_0010_0000,
        S_LINK  = 11'b000_0100_0000,
        S_CHK   = 11'b000_1000_0000,
        S_CMP   = 11'b001_0000_0000,
        S_FREE  = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_res   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        o_cmd.act  = ACT_NONE;
        o_cmd.res  = r_res;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.act = ACT_CLEAR;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.act = ACT_LOAD;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.act = ACT_DIV;
                if (i_sts.div_done) n_state = S_RDB;
            end
            S_RDB: begin
                o_cmd.act = ACT_RD_BUCKET;
                n_state   = S_DISP;
            end
            S_DISP: begin
                case (i_sts.op)
                    OP_INSERT: begin
                        if (!i_sts.free_nil) begin
                            o_cmd.act = ACT_ALLOC_RD;
                            n_state   = S_ALLOC;
                        end else if (!i_sts.fresh_nil) begin
                            n_state = S_ALLOC;
                        end else begin
                            n_res   = ST_FULL;
                            n_state = S_FIN;
                        end
                    end
                    OP_REMOVE, OP_SEARCH: begin
                        o_cmd.act = ACT_WALK_START;
                        n_state   = S_CHK;
                    end
                    default: begin
                        n_res   = ST_ABSENT;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_ALLOC: begin
                o_cmd.act = ACT_ALLOC;
                n_res     = ST_OK;
                n_state   = i_sts.link_head ? S_FIN : S_LINK;
            end
            S_LINK: begin
                o_cmd.act = ACT_LINK;
                n_state   = S_FIN;
            end
            S_CHK: begin
                if (i_sts.cur_nil) begin
                    n_res   = ST_ABSENT;
                    n_state = S_FIN;
                end else begin
                    o_cmd.act = ACT_RD_NODE;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.match) begin
                    n_res = ST_OK;
                    if (i_sts.op == OP_REMOVE) begin
                        o_cmd.act = ACT_UNLINK;
                        n_state   = S_FREE;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.act = ACT_ADVANCE;
                    n_state   = S_CHK;
                end
            end
            S_FREE: begin
                o_cmd.act = ACT_FREE;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.act = ACT_RESULT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

// ===== sv/chs_dpath.sv =====
// datapath: divider, bucket tables, node pool and result register
module chs_dpath #(
    parameter int BUCKETS = 256,
    parameter int NODES   = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [chs_pkg::CFG_W-1:0]  i_cfg_data,
    input  chs_pkg::t_req              i_req,
    input  chs_pkg::t_cmd              i_cmd,
    output chs_pkg::t_sts              o_sts,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output chs_pkg::t_rsp              o_rsp
);
    import chs_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int LW = $clog2(NODES + 1);
    localparam int NW = $clog2(NODES);
    localparam logic [LW-1:0] NIL = LW'(NODES);

    logic [LW-1:0]    head_mem [BUCKETS];
    logic [LW-1:0]    tail_mem [BUCKETS];
    logic [KEY_W-1:0] key_mem  [NODES];
    logic [LW-1:0]    next_mem [NODES];

    logic [CFG_W-1:0] r_cfg;
    logic [BW-1:0]    r_clr;
    logic [KEY_W-1:0] r_key, r_sh;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [1:0]       r_op;
    logic [LW-1:0]    r_head_q, r_tail_q, r_next_q;
    logic [KEY_W-1:0] r_nkey_q;
    logic [LW-1:0]    r_cur, r_prev, r_new, r_free, r_fresh;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [CFG_W-1:0] eff;
    logic [REM_W:0]   rem2;
    logic [BW-1:0]    b_addr;
    logic [LW-1:0]    alloc_n;
    logic             free_nil;

    logic             h_we, t_we, nx_we, k_we;
    logic [BW-1:0]    ht_addr;
    logic [LW-1:0]    h_wd, t_wd, nx_wd;
    logic [NW-1:0]    nx_addr, nx_raddr;

    assign eff = (r_cfg == '0) ? CFG_W'(1) :
                 ((32'(r_cfg) > BUCKETS) ? CFG_W'(BUCKETS) : r_cfg);
    assign rem2     = {r_rem, r_sh[KEY_W-1]};
    assign b_addr   = BW'(r_rem);
    assign free_nil = (r_free == NIL);
    assign alloc_n  = free_nil ? r_fresh : r_free;
    assign nx_raddr = (i_cmd.act == ACT_ALLOC_RD) ? r_free[NW-1:0] : r_cur[NW-1:0];

    assign o_sts.clr_done  = (r_clr == BW'(BUCKETS - 1));
    assign o_sts.div_done  = (r_cnt == CNT_W'(KEY_W - 1));
    assign o_sts.op        = r_op;
    assign o_sts.free_nil  = free_nil;
    assign o_sts.fresh_nil = (r_fresh == NIL);
    assign o_sts.link_head = (r_head_q == NIL) || (r_tail_q == NIL);
    assign o_sts.cur_nil   = (r_cur == NIL);
    assign o_sts.match     = (r_nkey_q == r_key);
    assign o_sts.out_busy  = r_out_valid && !i_rsp_ready;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // table write ports
    always_comb begin
        h_we    = 1'b0;
        t_we    = 1'b0;
        nx_we   = 1'b0;
        k_we    = 1'b0;
        ht_addr = b_addr;
        h_wd    = alloc_n;
        t_wd    = alloc_n;
        nx_addr = alloc_n[NW-1:0];
        nx_wd   = NIL;
        case (i_cmd.act)
            ACT_CLEAR: begin
                h_we    = 1'b1;
                t_we    = 1'b1;
                ht_addr = r_clr;
                h_wd    = NIL;
                t_wd    = NIL;
            end
            ACT_ALLOC: begin
                k_we  = 1'b1;
                nx_we = 1'b1;
                t_we  = 1'b1;
                h_we  = o_sts.link_head;
            end
            ACT_LINK: begin
                nx_we   = 1'b1;
                nx_addr = r_tail_q[NW-1:0];
                nx_wd   = r_new;
            end
            ACT_UNLINK: begin
                h_we    = (r_prev == NIL);
                h_wd    = r_next_q;
                nx_we   = (r_prev != NIL);
                nx_addr = r_prev[NW-1:0];
                nx_wd   = r_next_q;
                t_we    = (r_tail_q == r_cur);
                t_wd    = r_prev;
            end
            ACT_FREE: begin
                nx_we   = 1'b1;
                nx_addr = r_cur[NW-1:0];
                nx_wd   = r_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (h_we) head_mem[ht_addr] <= h_wd;
        if (t_we) tail_mem[ht_addr] <= t_wd;
        if (i_cmd.act == ACT_RD_BUCKET) begin
            r_head_q <= head_mem[b_addr];
            r_tail_q <= tail_mem[b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (k_we) key_mem[alloc_n[NW-1:0]] <= r_key;
        if (nx_we) next_mem[nx_addr] <= nx_wd;
        if (i_cmd.act == ACT_RD_NODE) r_nkey_q <= key_mem[r_cur[NW-1:0]];
        if (i_cmd.act == ACT_RD_NODE || i_cmd.act == ACT_ALLOC_RD) begin
            r_next_q <= next_mem[nx_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_clr       <= '0;
            r_free      <= NIL;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (i_cmd.act == ACT_CLEAR) r_clr <= r_clr + BW'(1);
            if (i_cmd.act == ACT_ALLOC) begin
                if (free_nil) r_fresh <= r_fresh + LW'(1);
                else          r_free  <= r_next_q;
            end
            if (i_cmd.act == ACT_FREE) r_free <= r_cur;
            if (i_cmd.act == ACT_RESULT)    r_out_valid <= 1'b1;
            else if (i_rsp_ready)           r_out_valid <= 1'b0;
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.act)
            ACT_LOAD: begin
                r_key <= i_req.key;
                r_sh  <= i_req.key;
                r_op  <= i_req.op;
                r_cnt <= '0;
                r_rem <= '0;
            end
            ACT_DIV: begin
                r_sh  <= {r_sh[KEY_W-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
                if (rem2 >= {1'b0, eff}) r_rem <= REM_W'(rem2 - {1'b0, eff});
                else                     r_rem <= REM_W'(rem2);
            end
            ACT_ALLOC: r_new <= alloc_n;
            ACT_WALK_START: begin
                r_cur  <= r_head_q;
                r_prev <= NIL;
            end
            ACT_ADVANCE: begin
                r_prev <= r_cur;
                r_cur  <= r_next_q;
            end
            ACT_RESULT: begin
                r_out.status <= i_cmd.res;
                r_out.bucket <= OUT_BW'(r_rem);
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/chained_hash_set.sv =====
// top level of the chained hash set
// Usage:
//   i_req carries one request item (op, key); o_rsp returns one result item
//   (status, bucket) per request, in request order. i_cfg_we/i_cfg_data write
//   the bucket count; the user does it while the block is idle (unenforced).
// Sequence:
//   the bucket is found by a one-bit-per-cycle restoring divider, then the
//   bucket tables are read. Insert then allocates a node and links it in;
//   search and remove read and compare each chain node visited; last the
//   result register is loaded. One item is in work at a time; i_req.ready is
//   high only when idle.
// Reset:
//   synchronous, active low; after it the block clears the bucket head and
//   tail tables, one bucket per cycle, all BUCKETS of them, before taking an
//   item. Configuration writes are taken during that pass.
// Stall:
//   a result waits in the output register while o_rsp.ready is low; the
//   next item is still accepted and is held back only at its own result.
module chained_hash_set #(
    parameter int BUCKETS = 256,
    parameter int NODES   = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [chs_pkg::CFG_W-1:0] i_cfg_data,
    chs_stream_if.sink                i_req,
    chs_stream_if.source              o_rsp
);
    import chs_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic rsp_valid;
    t_rsp rsp;

    chs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    chs_dpath #(
        .BUCKETS (BUCKETS),
        .NODES   (NODES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (rsp)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = rsp_valid;
    assign o_rsp.data  = rsp;

endmodule

// ===== sv/chs_checker.sv =====
// port-level checker of the chained hash set and its bind
`include "chained_hash_set_assert.svh"

module chs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_status
);
    import chs_pkg::*;

    logic in_acc;
    logic in_acc_empty;
    logic st_legal;
    logic out_stall;
    assign in_acc       = i_in_valid && i_in_ready;
    assign in_acc_empty = in_acc && !i_out_valid;
    assign st_legal     = (i_out_status == ST_OK) || (i_out_status == ST_ABSENT)
                          || (i_out_status == ST_FULL);
    assign out_stall    = i_out_valid && !i_out_ready;

    `CHS_ASSERT(a_one_item_at_a_time, i_clk, i_rst_n, in_acc |=> !i_in_ready)
    `CHS_ASSERT(a_no_result_right_after_accept, i_clk, i_rst_n, in_acc_empty |=> !i_out_valid)
    `CHS_ASSERT(a_status_code, i_clk, i_rst_n, i_out_valid |-> st_legal)
    `CHS_ASSERT(a_result_held, i_clk, i_rst_n, out_stall |=> i_out_valid)
    `CHS_ASSERT_ALWAYS(a_reset_empties_output, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind chained_hash_set chs_checker u_chs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_status (o_rsp.data.status)
);
